### src/ssra_pkg.sv
package ssra_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam logic [15:0] ONE_FIXED       = 16'd4096;
  localparam logic [31:0] MAX32           = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    STAT_UPDATED     = 3'd0,
    STAT_INSERTED    = 3'd1,
    STAT_DROPPED     = 3'd2,
    STAT_READ_OK     = 3'd3,
    STAT_READ_BEYOND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_REQ,
    S_RD_CAP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_FINISH
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX32 : s[31:0];
  endfunction

endpackage

### src/ssra_in_if.sv
interface ssra_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] key_index;
  logic [15:0] weight;
  logic        last_of_track;
  logic [7:0]  read_position;

  modport source (output valid, action, key_index, weight, last_of_track, read_position,
                  input ready);
  modport sink   (input valid, action, key_index, weight, last_of_track, read_position,
                  output ready);
endinterface

### src/ssra_out_if.sv
interface ssra_out_if;
  logic             valid;
  logic             ready;
  ssra_pkg::status_t status;
  logic [31:0]      entry_index;
  logic [31:0]      entry_value;
  logic [8:0]       entry_count;
  logic [31:0]      track_total;

  modport source (output valid, status, entry_index, entry_value, entry_count, track_total,
                  input ready);
  modport sink   (input valid, status, entry_index, entry_value, entry_count, track_total,
                  output ready);
endinterface

### src/ssra_cfg_if.sv
interface ssra_cfg_if;
  logic valid;
  logic ready;
  logic use_weights;

  modport source (output valid, use_weights, input ready);
  modport sink   (input valid, use_weights, output ready);
endinterface

### src/sorted_sparse_row_accumulator_unit.sv
// Sorted sparse row accumulator.
// in_ch carries one item: an add (key_index, weight, last_of_track) or a
// read (read_position). out_ch returns exactly one result item per input item:
// status, the entry touched or read, the entry count and the track total.
// cfg_ch writes use_weights (1: add the item weight, 0: add 1.0 per item);
// write it only while the block is idle. cfg_ch is always ready.
// The table lives in two single-port-read memories (index, value), sorted by
// ascending index. Each memory read is registered, and one read port does
// all the work, so the time from one accepted item to the next follows the
// entry count n through these states:
//   read item in range  : S_RD_REQ, S_RD_CAP, S_FINISH; read beyond: S_FINISH
//   add, update at pos p: S_SCAN_RD, S_SCAN_CMP for positions 0..p, S_FINISH
//   add, insert at pos p: scan, S_PLACE, S_SHIFT_RD/WR per entry p..n-1, S_INSERT, S_FINISH
//   add, table full     : scan to the end or a larger index, S_PLACE, S_FINISH
// One item is processed at a time; in_ch.ready is high only between items.
// A finished result sits in the output register; a new item is accepted while
// it waits, and the next result holds in S_FINISH until out_ch.ready frees it.
// Reset empties the table (count 0), clears the track total and use_weights;
// table memories are not cleared, no entry is read before it is written.
module sorted_sparse_row_accumulator_unit #(
  parameter int unsigned TABLE_DEPTH = ssra_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ssra_in_if.sink    in_ch,
  ssra_out_if.source out_ch,
  ssra_cfg_if.sink   cfg_ch
);
  import ssra_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [31:0] idx_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [31:0]   total_r;
  logic          use_w_r;
  logic          out_valid_r;

  logic [CW-1:0] pos_r, k_r;
  logic [31:0]   fidx_r;
  logic [15:0]   add_r;
  logic [31:0]   rd_idx_r, rd_val_r;
  status_t       res_status_r;
  logic [31:0]   res_idx_r, res_val_r;
  status_t       out_status_r;
  logic [31:0]   out_idx_r, out_val_r, out_total_r;
  logic [8:0]    out_count_r;

  logic [15:0]   in_add;
  logic          rd_in_range;
  logic          idx_lt, idx_eq;
  logic          scan_last;
  logic [CW-1:0] k_m1;
  logic [31:0]   upd_val;
  logic          out_free;

  logic          mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0]   mem_widx, mem_wval;

  assign in_add      = use_w_r ? in_ch.weight : ONE_FIXED;
  assign rd_in_range = CMPW'(in_ch.read_position) < CMPW'(count_r);
  assign idx_lt      = rd_idx_r < fidx_r;
  assign idx_eq      = rd_idx_r == fidx_r;
  assign scan_last   = CW'(pos_r + 1'b1) == count_r;
  assign k_m1        = k_r - 1'b1;
  assign upd_val     = sat_add(rd_val_r, {16'b0, add_r});
  assign out_free    = !out_valid_r || out_ch.ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_index = out_idx_r;
  assign out_ch.entry_value = out_val_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.track_total = out_total_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.action) begin
            state_nxt = rd_in_range ? S_RD_REQ : S_FINISH;
          end else begin
            state_nxt = (count_r == '0) ? S_PLACE : S_SCAN_RD;
          end
        end
      end
      S_RD_REQ:   state_nxt = S_RD_CAP;
      S_RD_CAP:   state_nxt = S_FINISH;
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        priority if (idx_lt) begin
          state_nxt = scan_last ? S_PLACE : S_SCAN_RD;
        end else if (idx_eq) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        priority if (count_r == DEPTH_C) begin
          state_nxt = S_FINISH;
        end else if (pos_r == count_r) begin
          state_nxt = S_INSERT;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = (k_m1 == pos_r) ? S_INSERT : S_SHIFT_RD;
      S_INSERT:   state_nxt = S_FINISH;
      S_FINISH:   state_nxt = out_free ? S_IDLE : S_FINISH;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // one read port, one write port shared by scan, shift and insert
  always_comb begin
    mem_we    = 1'b0;
    mem_raddr = pos_r[AW-1:0];
    mem_waddr = pos_r[AW-1:0];
    mem_widx  = fidx_r;
    mem_wval  = {16'b0, add_r};
    unique case (state_r)
      S_SHIFT_RD: mem_raddr = k_m1[AW-1:0];
      S_SCAN_CMP: begin
        mem_we   = idx_eq;
        mem_wval = upd_val;
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_widx  = rd_idx_r;
        mem_wval  = rd_val_r;
      end
      S_INSERT: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      idx_mem[mem_waddr] <= mem_widx;
      val_mem[mem_waddr] <= mem_wval;
    end
    rd_idx_r <= idx_mem[mem_raddr];
    rd_val_r <= val_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      use_w_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        use_w_r <= cfg_ch.use_weights;
      end
      if (state_r == S_IDLE && in_ch.valid && !in_ch.action && in_ch.last_of_track) begin
        total_r <= sat_add(total_r, {16'b0, in_add});
      end
      if (state_r == S_INSERT) begin
        count_r <= count_r + 1'b1;
      end
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        fidx_r       <= in_ch.key_index;
        add_r        <= in_add;
        pos_r        <= in_ch.action ? CW'(in_ch.read_position) : '0;
        res_status_r <= STAT_READ_BEYOND;
        res_idx_r    <= '0;
        res_val_r    <= '0;
      end
      S_RD_CAP: begin
        res_status_r <= STAT_READ_OK;
        res_idx_r    <= rd_idx_r;
        res_val_r    <= rd_val_r;
      end
      S_SCAN_CMP: begin
        if (idx_lt) begin
          pos_r <= pos_r + 1'b1;
        end else if (idx_eq) begin
          res_status_r <= STAT_UPDATED;
          res_idx_r    <= fidx_r;
          res_val_r    <= upd_val;
        end
      end
      S_PLACE: begin
        k_r          <= count_r;
        res_status_r <= STAT_DROPPED;
        res_idx_r    <= fidx_r;
        res_val_r    <= '0;
      end
      S_SHIFT_WR: k_r <= k_m1;
      S_INSERT: begin
        res_status_r <= STAT_INSERTED;
        res_idx_r    <= fidx_r;
        res_val_r    <= {16'b0, add_r};
      end
      S_FINISH: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_idx_r    <= res_idx_r;
          out_val_r    <= res_val_r;
          out_count_r  <= 9'(count_r);
          out_total_r  <= total_r;
        end
      end
      default: ;
    endcase
  end

endmodule

### src/ssra_checker.sv
module ssra_checker #(
  parameter int unsigned DEPTH = ssra_pkg::TABLE_DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input ssra_pkg::status_t status,
  input logic [31:0]       entry_index,
  input logic [31:0]       entry_value,
  input logic [8:0]        entry_count
);
  import ssra_pkg::*;

  localparam logic [8:0] FULL_COUNT = 9'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_value))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(entry_count) <= DEPTH)
    else $error("entry count above table depth");

  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_READ_BEYOND |-> entry_index == '0 && entry_value == '0)
    else $error("read beyond count returned data");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_DROPPED |-> entry_value == '0 && entry_count == FULL_COUNT)
    else $error("item dropped while table not full");

endmodule

bind sorted_sparse_row_accumulator_unit ssra_checker #(.DEPTH(TABLE_DEPTH)) u_ssra_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .entry_index (out_ch.entry_index),
  .entry_value (out_ch.entry_value),
  .entry_count (out_ch.entry_count)
);
